>>> hdl/ptfr_pkg.sv
// ----------------------------------------------------------------------------
// ptfr_pkg
// shared widths, codes and controller command type for the tile flip/rotate unit
// ----------------------------------------------------------------------------
package ptfr_pkg;

  localparam int DEF_MAX_SIDE = 64;

  localparam int KIND_W   = 3;
  localparam int COORD_W  = 6;
  localparam int PIX_W    = 32;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [KIND_W-1:0] KIND_LOAD   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FLIP_V = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FLIP_H = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ROT    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONSQUARE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] SIDE_RESET = 7'd64;

  // controller to datapath commands
  typedef struct packed {
    logic capture;   // latch the input beat
    logic exec;      // map coordinate, access store, update orientation
    logic load_out;  // move result into the output register
  } ptfr_cmd_t;

endpackage

>>> hdl/ptfr_ctrl.sv
// ----------------------------------------------------------------------------
// ptfr_ctrl
// sequencing fsm and output valid tracking for the tile flip/rotate unit
// ----------------------------------------------------------------------------
module ptfr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output ptfr_pkg::ptfr_cmd_t cmd
);
  import ptfr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MAP  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    cmd.capture  = 1'b0;
    cmd.exec     = 1'b0;
    cmd.load_out = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_MAP;
        end
      end
      S_MAP: begin
        cmd.exec  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  // an accepted beat is executed in the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> cmd.exec)
    else $error("accepted beat not executed");

  // a waiting result is never overwritten
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !(out_valid_r && out_stall))
    else $error("output register overwritten while stalled");

  // a stalled result stays valid
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

  // no new beat is taken while one is in flight
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> in_stall)
    else $error("input taken during execution");
`endif

endmodule

>>> hdl/ptfr_datapath.sv
// ----------------------------------------------------------------------------
// ptfr_datapath
// config registers, orientation state, coordinate mapping and pixel store
// ----------------------------------------------------------------------------
module ptfr_datapath #(
  parameter int MAX_SIDE = ptfr_pkg::DEF_MAX_SIDE
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ptfr_pkg::ptfr_cmd_t            cmd,
  input  logic                           cfg_we,
  input  logic [ptfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ptfr_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic [ptfr_pkg::KIND_W-1:0]    in_kind,
  input  logic [ptfr_pkg::COORD_W-1:0]   in_column,
  input  logic [ptfr_pkg::COORD_W-1:0]   in_row,
  input  logic [ptfr_pkg::PIX_W-1:0]     in_pixel_in,
  output logic [ptfr_pkg::PIX_W-1:0]     out_pixel_out,
  output logic [ptfr_pkg::STATUS_W-1:0]  out_status
);
  import ptfr_pkg::*;

  localparam int IW    = $clog2(MAX_SIDE);
  localparam int SW0   = $clog2(MAX_SIDE + 1);
  localparam int SW    = (SW0 > CFG_W) ? SW0 : CFG_W;
  localparam int DEPTH = 1 << (2 * IW);
  localparam logic [SW-1:0] SIDE_MAX = SW'(MAX_SIDE);

  logic [CFG_W-1:0]    tile_width_r, tile_height_r;
  logic [2:0]          orient_r, orient_nxt;
  logic [KIND_W-1:0]   kind_r;
  logic [COORD_W-1:0]  col_r, row_r;
  logic [PIX_W-1:0]    pix_r;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                rd_ok_r;
  logic [PIX_W-1:0]    rdata_r;
  logic [PIX_W-1:0]    pixel_out_r;
  logic [STATUS_W-1:0] status_out_r;
  logic [PIX_W-1:0]    mem [DEPTH];

  logic [SW-1:0]   w_eff, h_eff, c_ext, r_ext, u_full, v_full;
  logic [IW-1:0]   u, v, x, y;
  logic [2*IW-1:0] addr;
  logic            is_access, in_range, mem_we;

  // saturate sizes at the store's side
  assign w_eff = (SW'(tile_width_r)  > SIDE_MAX) ? SIDE_MAX : SW'(tile_width_r);
  assign h_eff = (SW'(tile_height_r) > SIDE_MAX) ? SIDE_MAX : SW'(tile_height_r);
  assign c_ext = SW'(col_r);
  assign r_ext = SW'(row_r);

  assign is_access = (kind_r == KIND_LOAD) || (kind_r == KIND_READ);
  assign in_range  = (c_ext < w_eff) && (r_ext < h_eff);

  // mirror then optional axis swap
  assign u_full = orient_r[0] ? (w_eff - SW'(1) - c_ext) : c_ext;
  assign v_full = orient_r[1] ? (h_eff - SW'(1) - r_ext) : r_ext;
  assign u      = u_full[IW-1:0];
  assign v      = v_full[IW-1:0];
  assign x      = orient_r[2] ? v : u;
  assign y      = orient_r[2] ? u : v;
  assign addr   = {y, x};

  assign mem_we = cmd.exec && (kind_r == KIND_LOAD) && in_range;

  always_comb begin
    orient_nxt = orient_r;
    status_nxt = ST_OK;
    case (kind_r)
      KIND_LOAD, KIND_READ: begin
        if (!in_range) begin
          status_nxt = ST_RANGE;
        end
      end
      KIND_FLIP_V: begin
        orient_nxt = orient_r ^ 3'b010;
      end
      KIND_FLIP_H: begin
        orient_nxt = orient_r ^ 3'b001;
      end
      KIND_ROT: begin
        if (w_eff != h_eff) begin
          status_nxt = ST_NONSQUARE;
        end else begin
          orient_nxt = {~orient_r[2], orient_r[0], ~orient_r[1]};
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_width_r  <= SIDE_RESET;
      tile_height_r <= SIDE_RESET;
      orient_r      <= 3'b000;
    end else begin
      if (cfg_we && (cfg_index == REG_TILE_WIDTH)) begin
        tile_width_r <= cfg_wdata;
      end
      if (cfg_we && (cfg_index == REG_TILE_HEIGHT)) begin
        tile_height_r <= cfg_wdata;
      end
      if (cmd.exec) begin
        orient_r <= orient_nxt;
      end
    end
  end

  // input beat and per-item results
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_kind;
      col_r  <= in_column;
      row_r  <= in_row;
      pix_r  <= in_pixel_in;
    end
    if (cmd.exec) begin
      status_r <= status_nxt;
      rd_ok_r  <= (kind_r == KIND_READ) && in_range;
    end
    if (cmd.load_out) begin
      pixel_out_r  <= rd_ok_r ? rdata_r : '0;
      status_out_r <= status_r;
    end
  end

  // pixel store, one port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= pix_r;
    end
    if (cmd.exec && is_access) begin
      rdata_r <= mem[addr];
    end
  end

  assign out_pixel_out = pixel_out_r;
  assign out_status    = status_out_r;

endmodule

>>> hdl/pixel_tile_flip_rotate_unit.sv
// ----------------------------------------------------------------------------
// pixel_tile_flip_rotate_unit
// one tile of rgba pixels with flip and 90 degree rotation by coordinate remap
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_stall) carries one command beat: load a pixel,
//   flip vertical, flip horizontal, rotate right, or read a pixel at a
//   tile-local column/row. each beat yields exactly one result beat on the
//   output channel (out_valid/out_stall) with a pixel and a status code.
//   pixels never move; a 3-bit orientation maps every coordinate to storage.
//   timing: a beat is accepted in the idle state, the next cycle maps the
//   coordinate and accesses the single-port store, and the done state then
//   loads the output register once it is free. a new beat is taken only
//   after the fsm has walked through idle, map and done back to idle.
//   a pending result may sit in the output register while the next beat is
//   accepted and executed; the unit waits in done only if that result is
//   still stalled. a stalled result holds its value.
//   reset clears orientation to identity and tile sizes to 64 by 64; the
//   pixel store is not cleared, reads of unwritten cells return garbage.
//   the user must write tile sizes on cfg port only while idle; not enforced.
// ----------------------------------------------------------------------------
module pixel_tile_flip_rotate_unit #(
  parameter int MAX_SIDE = ptfr_pkg::DEF_MAX_SIDE
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ptfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ptfr_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [ptfr_pkg::KIND_W-1:0]    in_kind,
  input  logic [ptfr_pkg::COORD_W-1:0]   in_column,
  input  logic [ptfr_pkg::COORD_W-1:0]   in_row,
  input  logic [ptfr_pkg::PIX_W-1:0]     in_pixel_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ptfr_pkg::PIX_W-1:0]     out_pixel_out,
  output logic [ptfr_pkg::STATUS_W-1:0]  out_status
);
  import ptfr_pkg::*;

  ptfr_cmd_t cmd;

  // sequencing and output handshake
  ptfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // remap, orientation state and pixel store
  ptfr_datapath #(
    .MAX_SIDE (MAX_SIDE)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_kind       (in_kind),
    .in_column     (in_column),
    .in_row        (in_row),
    .in_pixel_in   (in_pixel_in),
    .out_pixel_out (out_pixel_out),
    .out_status    (out_status)
  );

endmodule
